// ===== src/bgrf_pkg.sv =====
// ----------------------------------------------------------------------------
// bgrf_pkg
// types, widths and codes shared by the bit granular ring fifo
// ----------------------------------------------------------------------------
package bgrf_pkg;

   localparam int DATA_W = 64;
   localparam int CNT_W  = 7;
   localparam int CAP_W  = 11;
   localparam int STAT_W = 2;
   localparam int FILL_W = 14;

   typedef logic [STAT_W-1:0] status_type;

   localparam status_type ST_DONE      = 2'd0;
   localparam status_type ST_NO_SPACE  = 2'd1;
   localparam status_type ST_UNDERFLOW = 2'd2;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef struct packed {
      logic [3:0] len;
      logic [7:0] merged;
      logic [7:0] taken;
      logic [7:0] taken_rev;
   } chunk_type;

   function automatic logic [7:0] rev8(input logic [7:0] value);
      logic [7:0] result;
      for (int i = 0; i < 8; i++) begin
         result[i] = value[7-i];
      end
      return result;
   endfunction

endpackage

// ===== src/bgrf_chunk_lane.sv =====
// ----------------------------------------------------------------------------
// bgrf_chunk_lane
// byte lane: sizes the next piece of a word inside one store byte, merges
// pushed bits into the byte and extracts popped bits from it
// ----------------------------------------------------------------------------
module bgrf_chunk_lane (
   input  logic [2:0]                 offset,
   input  logic [bgrf_pkg::CNT_W-1:0] remaining,
   input  logic [7:0]                 src_bits,
   input  logic [7:0]                 mem_byte,
   output bgrf_pkg::chunk_type        chunk
);
   import bgrf_pkg::*;

   logic [3:0] avail;
   logic [3:0] len;
   logic [8:0] low_wide;
   logic [7:0] low_mask;
   logic [7:0] mask;
   logic [7:0] taken;

   always_comb begin
      avail    = 4'd8 - {1'b0, offset};
      len      = (remaining < CNT_W'(avail)) ? remaining[3:0] : avail;
      low_wide = (9'h001 << len) - 9'h001;
      low_mask = low_wide[7:0];
      mask     = low_mask << offset;
      taken    = (mem_byte >> offset) & low_mask;

      chunk.len       = len;
      chunk.merged    = (mem_byte & ~mask) | ((src_bits << offset) & mask);
      chunk.taken     = taken;
      chunk.taken_rev = rev8(taken) >> (4'd8 - len);
   end

endmodule

// ===== src/bit_granular_ring_fifo.sv =====
// ----------------------------------------------------------------------------
// bit_granular_ring_fifo
// lsb first bit stream fifo: pushes and pops words of 1 to 64 bits through a
// ring of bits held in a byte store, one store byte at a time; no new word is taken until the current one is finished
//
//   port group   direction   handshake        carries
//   req_         in          valid / stall    mode, bit_count, data_in, reverse
//   rsp_         out         valid / stall    data_out, status, fill_bits
//   csr_         in          valid / ready    capacity in bytes
//
// push: accept, then align if reversed and shorter than 64 bits, then a write
//       per full byte or a read and a merge per partial byte, then the result
// pop:  accept, read issue, a take per byte, then align if not reversed and
//       shorter than 64 bits, then the result; the store is read or written in turn
// rejected or empty words go straight to the result; reset empties the ring at once
// a stalled result holds back only the end of the next word
// ----------------------------------------------------------------------------
module bit_granular_ring_fifo #(
   parameter int STORE_BYTES    = 1024,
   parameter int MAX_FIELD_BITS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [bgrf_pkg::CNT_W-1:0]  req_bit_count,
   input  logic [bgrf_pkg::DATA_W-1:0] req_data_in,
   input  logic                        req_reverse,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bgrf_pkg::DATA_W-1:0] rsp_data_out,
   output logic [bgrf_pkg::STAT_W-1:0] rsp_status,
   output logic [bgrf_pkg::FILL_W-1:0] rsp_fill_bits,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bgrf_pkg::CAP_W-1:0]  csr_wdata
);
   import bgrf_pkg::*;

   localparam int FW = MAX_FIELD_BITS;
   localparam int AW = $clog2(STORE_BYTES);
   localparam int PW = $clog2(STORE_BYTES * 8);
   localparam int RW = PW + 1;
   localparam int CW = $clog2(STORE_BYTES + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ALIGN = 3'd1;
   localparam logic [2:0] S_CHUNK = 3'd2;
   localparam logic [2:0] S_MERGE = 3'd3;
   localparam logic [2:0] S_TAKE  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     cap_ff, cap_in;
   logic [PW-1:0]     wp_ff, wp_in;
   logic [PW-1:0]     rp_ff, rp_in;
   logic [RW-1:0]     held_ff, held_in;
   logic              mode_ff, mode_in;
   logic              rev_ff, rev_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  skip_ff, skip_in;
   logic [FW-1:0]     sr_ff, sr_in;
   status_type        status_ff, status_in;
   logic [7:0]        rd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0] rsp_fill_ff, rsp_fill_in;

   logic [7:0]        mem [STORE_BYTES];
   logic              mem_we;
   logic              mem_rd;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic [7:0]        wr_data;

   chunk_type         chunk;
   logic [PW-1:0]     pos;
   logic [PW:0]       pos_sum;
   logic [PW-1:0]     pos_next;
   logic [RW-1:0]     ring;
   logic [CNT_W-1:0]  n_sat;
   logic [RW:0]       push_sum;
   logic              no_space;
   logic              underflow;
   logic [FW-1:0]     data_rev;
   logic [3:0]        align_amt;
   logic [CNT_W-1:0]  rem_after;
   logic [FW-1:0]     sr_chunk;
   logic [FW+7:0]     sr_wide;

   bgrf_chunk_lane u_lane (
      .offset    (pos[2:0]),
      .remaining (rem_ff),
      .src_bits  (sr_ff[7:0]),
      .mem_byte  (rd_ff),
      .chunk     (chunk)
   );

   always_comb begin
      for (int i = 0; i < FW; i++) begin
         data_rev[i] = req_data_in[FW-1-i];
      end
   end

   always_comb begin
      ring      = RW'({cap_ff, 3'b000});
      pos       = (mode_ff == MODE_POP) ? rp_ff : wp_ff;
      pos_sum   = (PW+1)'(pos) + (PW+1)'(chunk.len);
      pos_next  = ((RW)'(pos_sum) == ring) ? '0 : pos_sum[PW-1:0];
      rem_after = rem_ff - CNT_W'(chunk.len);
      n_sat     = (32'(req_bit_count) > FW) ? CNT_W'(FW) : req_bit_count;
      push_sum  = (RW+1)'(held_ff) + (RW+1)'(n_sat);
      no_space  = push_sum > (RW+1)'(ring);
      underflow = (RW+1)'(n_sat) > (RW+1)'(held_ff);
      align_amt = (skip_ff > CNT_W'(8)) ? 4'd8 : skip_ff[3:0];
      if ((mode_ff == MODE_POP) && !rev_ff) begin
         sr_wide = {chunk.taken, sr_ff} >> chunk.len;
      end else begin
         sr_wide = {8'h00, sr_ff} >> chunk.len;
      end
      if ((mode_ff == MODE_POP) && rev_ff) begin
         sr_chunk = (sr_ff << chunk.len) | FW'(chunk.taken_rev);
      end else begin
         sr_chunk = sr_wide[FW-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      held_in       = held_ff;
      mode_in       = mode_ff;
      rev_in        = rev_ff;
      rem_in        = rem_ff;
      skip_in       = skip_ff;
      sr_in         = sr_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      mem_we        = 1'b0;
      mem_rd        = 1'b0;
      rd_addr       = AW'(pos[PW-1:3]);
      wr_addr       = AW'(pos[PW-1:3]);
      wr_data       = chunk.merged;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               rev_in    = req_reverse;
               rem_in    = n_sat;
               skip_in   = CNT_W'(FW) - n_sat;
               status_in = ST_DONE;
               if (req_mode == MODE_PUSH) begin
                  sr_in = req_reverse ? data_rev : req_data_in[FW-1:0];
               end else begin
                  sr_in = '0;
               end
               if (n_sat == '0) begin
                  state_in = S_DONE;
               end else if ((req_mode == MODE_PUSH) && no_space) begin
                  status_in = ST_NO_SPACE;
                  state_in  = S_DONE;
               end else if ((req_mode == MODE_POP) && underflow) begin
                  status_in = ST_UNDERFLOW;
                  state_in  = S_DONE;
               end else if (req_mode == MODE_PUSH) begin
                  held_in  = push_sum[RW-1:0];
                  state_in = (req_reverse && (n_sat != CNT_W'(FW))) ? S_ALIGN : S_CHUNK;
               end else begin
                  held_in  = held_ff - RW'(n_sat);
                  state_in = S_CHUNK;
               end
            end
            if (csr_valid) begin
               if (csr_wdata == '0) begin
                  cap_in = CW'(1);
               end else if (32'(csr_wdata) > STORE_BYTES) begin
                  cap_in = CW'(STORE_BYTES);
               end else begin
                  cap_in = CW'(csr_wdata);
               end
               wp_in   = '0;
               rp_in   = '0;
               held_in = '0;
            end
         end
         S_ALIGN: begin
            sr_in   = sr_ff >> align_amt;
            skip_in = skip_ff - CNT_W'(align_amt);
            if (skip_ff == CNT_W'(align_amt)) begin
               state_in = (mode_ff == MODE_PUSH) ? S_CHUNK : S_DONE;
            end
         end
         S_CHUNK: begin
            if ((mode_ff == MODE_PUSH) && (chunk.len == 4'd8)) begin
               mem_we  = 1'b1;
               wr_data = sr_ff[7:0];
               wp_in   = pos_next;
               sr_in   = sr_chunk;
               rem_in  = rem_after;
               if (rem_after == '0) begin
                  state_in = S_DONE;
               end
            end else begin
               mem_rd   = 1'b1;
               state_in = (mode_ff == MODE_PUSH) ? S_MERGE : S_TAKE;
            end
         end
         S_MERGE: begin
            mem_we  = 1'b1;
            wp_in   = pos_next;
            sr_in   = sr_chunk;
            rem_in  = rem_after;
            state_in = (rem_after == '0) ? S_DONE : S_CHUNK;
         end
         S_TAKE: begin
            rp_in  = pos_next;
            sr_in  = sr_chunk;
            rem_in = rem_after;
            if (rem_after != '0) begin
               mem_rd  = 1'b1;
               rd_addr = AW'(pos_next[PW-1:3]);
            end else if (!rev_ff && (skip_ff != '0)) begin
               state_in = S_ALIGN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_fill_in   = FILL_W'(held_ff);
               if ((mode_ff == MODE_POP) && (status_ff == ST_DONE)) begin
                  rsp_data_in = DATA_W'(sr_ff);
               end else begin
                  rsp_data_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_rd) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CW'(STORE_BYTES);
         wp_ff        <= '0;
         rp_ff        <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      rev_ff        <= rev_in;
      rem_ff        <= rem_in;
      skip_ff       <= skip_in;
      sr_ff         <= sr_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign csr_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_fill_bits = rsp_fill_ff;

   a_held_in_ring: assert property (@(posedge clock) disable iff (reset)
      held_ff <= ring)
      else $error("held bit count beyond ring size");

   a_pos_in_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((RW'(wp_ff) < ring) && (RW'(rp_ff) < ring)))
      else $error("ring position out of range");

   a_empty_aligned: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && (held_ff == '0)) |-> (wp_ff == rp_ff))
      else $error("empty ring with unequal positions");

   a_rem_live: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CHUNK) || (state_ff == S_MERGE) || (state_ff == S_TAKE))
         |-> (rem_ff != '0))
      else $error("byte step with no bits left");

   a_write_on_push: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mode_ff == MODE_PUSH))
      else $error("store write during pop");

endmodule

// ===== bench/tb_bit_granular_ring_fifo.sv =====
// ----------------------------------------------------------------------------
// tb_bit_granular_ring_fifo
// self-checking bench for the bit granular ring fifo: a directed table of
// corner cases, then fill and drain traffic with random sizes over a range of
// ring capacities and idle patterns, each result word checked field by field
// against the table's expected fields or a bit-level model of the ring
// ----------------------------------------------------------------------------
module tb_bit_granular_ring_fifo;
   timeunit 1ns;
   timeprecision 1ps;

   import bgrf_pkg::*;

   localparam int STORE_BYTES     = 1024;
   localparam int MAX_BITS        = 64;
   localparam int WORDS_PER_PHASE = 216;
   localparam int NUM_PHASES      = 9;
   localparam int DRAIN_CYCLES    = 40;

   localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

   localparam logic [CAP_W-1:0] CAP_PLAN [NUM_PHASES] = '{
      11'd1, 11'd2047, 11'd3, 11'd1024, 11'd9, 11'd2, 11'd64, 11'd1025, 11'd700
   };

   typedef struct packed {
      logic [DATA_W-1:0] data;
      status_type        status;
      logic [FILL_W-1:0] fill;
   } fifo_result_t;

   typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

   typedef struct packed {
      row_kind_t        kind;
      logic [CAP_W-1:0] cap_value;
      logic             mode;
      logic [CNT_W-1:0] count;
      logic [DATA_W-1:0] data;
      logic             rev;
      logic             typed;
      fifo_result_t     want;
   } directed_row_t;

   localparam directed_row_t PLAN [27] = '{
      '{ROW_WORD, 11'd0, MODE_POP, 7'd1, 64'h0, 1'b0, 1'b1, '{64'h0, ST_UNDERFLOW, 14'd0}},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd0, ALL_ONES, 1'b0, 1'b1, '{64'h0, ST_DONE, 14'd0}},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd64, ALL_ONES, 1'b0, 1'b1, '{64'h0, ST_DONE, 14'd64}},
      '{ROW_WORD, 11'd0, MODE_POP, 7'd64, 64'h0, 1'b0, 1'b1, '{ALL_ONES, ST_DONE, 14'd0}},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd64, 64'h0123_4567_89ab_cdef, 1'b1, 1'b1,
        '{64'h0, ST_DONE, 14'd64}},
      '{ROW_WORD, 11'd0, MODE_POP, 7'd64, 64'h0, 1'b1, 1'b1,
        '{64'h0123_4567_89ab_cdef, ST_DONE, 14'd0}},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd1, 64'h1, 1'b0, 1'b1, '{64'h0, ST_DONE, 14'd1}},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd7, 64'h7f, 1'b1, 1'b0, '0},
      '{ROW_WORD, 11'd0, MODE_POP, 7'd8, 64'h0, 1'b0, 1'b0, '0},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd100, 64'hdead_beef_cafe_f00d, 1'b0, 1'b0, '0},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd127, 64'h8000_0000_0000_0001, 1'b1, 1'b0, '0},
      '{ROW_WORD, 11'd0, MODE_POP, 7'd65, 64'h0, 1'b0, 1'b0, '0},
      '{ROW_WORD, 11'd0, MODE_POP, 7'd127, ALL_ONES, 1'b1, 1'b0, '0},
      '{ROW_WORD, 11'd0, MODE_POP, 7'd0, 64'h0, 1'b1, 1'b1, '{64'h0, ST_DONE, 14'd0}},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd3, 64'hffff_ffff_ffff_fffa, 1'b0, 1'b0, '0},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd20, 64'habcde, 1'b1, 1'b0, '0},
      '{ROW_CAP, 11'd0, MODE_PUSH, 7'd0, 64'h0, 1'b0, 1'b0, '0},
      '{ROW_WORD, 11'd0, MODE_POP, 7'd1, 64'h0, 1'b0, 1'b1, '{64'h0, ST_UNDERFLOW, 14'd0}},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd9, ALL_ONES, 1'b0, 1'b1, '{64'h0, ST_NO_SPACE, 14'd0}},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd8, 64'ha5, 1'b0, 1'b1, '{64'h0, ST_DONE, 14'd8}},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd1, 64'h1, 1'b0, 1'b1, '{64'h0, ST_NO_SPACE, 14'd8}},
      '{ROW_WORD, 11'd0, MODE_POP, 7'd8, 64'h0, 1'b0, 1'b1, '{64'ha5, ST_DONE, 14'd0}},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd5, 64'h15, 1'b1, 1'b0, '0},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd3, 64'h6, 1'b0, 1'b0, '0},
      '{ROW_WORD, 11'd0, MODE_POP, 7'd8, 64'h0, 1'b1, 1'b0, '0},
      '{ROW_CAP, 11'd2047, MODE_PUSH, 7'd0, 64'h0, 1'b0, 1'b0, '0},
      '{ROW_WORD, 11'd0, MODE_PUSH, 7'd64, 64'h0, 1'b0, 1'b0, '0}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_mode;
   logic [CNT_W-1:0]  req_bit_count;
   logic [DATA_W-1:0] req_data_in;
   logic              req_reverse;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [DATA_W-1:0] rsp_data_out;
   logic [STAT_W-1:0] rsp_status;
   logic [FILL_W-1:0] rsp_fill_bits;
   logic              csr_valid;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_wdata;

   logic [7:0]   ring_mem [STORE_BYTES];
   int unsigned  wr_bit;
   int unsigned  rd_bit;
   int unsigned  ring_fill;
   int unsigned  cap_bytes;

   fifo_result_t pending_words [$];
   int unsigned  bad_words = 0;
   int unsigned  tx_idle_pct = 0;
   int unsigned  rx_idle_pct = 0;

   bit_granular_ring_fifo #(
      .STORE_BYTES    (STORE_BYTES),
      .MAX_FIELD_BITS (MAX_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_bit_count (req_bit_count),
      .req_data_in   (req_data_in),
      .req_reverse   (req_reverse),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_out  (rsp_data_out),
      .rsp_status    (rsp_status),
      .rsp_fill_bits (rsp_fill_bits),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void set_capacity(input logic [CAP_W-1:0] value);
      if (value == 0) begin
         cap_bytes = 1;
      end else if (value > STORE_BYTES) begin
         cap_bytes = STORE_BYTES;
      end else begin
         cap_bytes = 32'(value);
      end
      wr_bit    = 0;
      rd_bit    = 0;
      ring_fill = 0;
   endfunction

   // bit b of the ring is bit b%8 of store byte b/8, both positions wrap
   function automatic fifo_result_t ring_predict(input logic mode,
         input logic [CNT_W-1:0] count, input logic [DATA_W-1:0] din, input logic rev);
      fifo_result_t res;
      int unsigned  n;
      int unsigned  pos;
      res = '0;
      res.status = ST_DONE;
      n = (count > MAX_BITS) ? MAX_BITS : 32'(count);
      if (n != 0) begin
         if (mode == MODE_PUSH) begin
            if (ring_fill + n > cap_bytes * 8) begin
               res.status = ST_NO_SPACE;
            end else begin
               for (int i = 0; i < n; i++) begin
                  pos = rev ? n - 1 - i : i;
                  ring_mem[wr_bit >> 3][wr_bit & 7] = din[pos];
                  wr_bit = (wr_bit + 1 == cap_bytes * 8) ? 0 : wr_bit + 1;
               end
               ring_fill += n;
            end
         end else if (n > ring_fill) begin
            res.status = ST_UNDERFLOW;
         end else begin
            for (int i = 0; i < n; i++) begin
               pos = rev ? n - 1 - i : i;
               res.data[pos] = ring_mem[rd_bit >> 3][rd_bit & 7];
               rd_bit = (rd_bit + 1 == cap_bytes * 8) ? 0 : rd_bit + 1;
            end
            ring_fill -= n;
         end
      end
      res.fill = ring_fill[FILL_W-1:0];
      return res;
   endfunction

   task automatic note_bad(input string what, input fifo_result_t want,
         input fifo_result_t got);
      bad_words++;
      if (bad_words <= 10) begin
         $display("%0t %s: expected data %h status %0d fill %0d", $realtime, what,
                  want.data, want.status, want.fill);
         $display("%0t %s: actual   data %h status %0d fill %0d", $realtime, what,
                  got.data, got.status, got.fill);
      end
   endtask

   task automatic send_word(input logic mode, input logic [CNT_W-1:0] count,
         input logic [DATA_W-1:0] din, input logic rev, output fifo_result_t predicted);
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_bit_count <= count;
      req_data_in   <= din;
      req_reverse   <= rev;
      do @(posedge clock); while (req_stall);
      predicted = ring_predict(mode, count, din, rev);
   endtask

   task automatic sender_gap();
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      set_capacity(value);
   endtask

   always @(posedge clock) begin : rx_check
      fifo_result_t got;
      fifo_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_data_out, rsp_status, rsp_fill_bits};
         if (pending_words.size() == 0) begin
            note_bad("unexpected word", '0, got);
         end else begin
            want = pending_words.pop_front();
            if (got.data !== want.data || got.status !== want.status
                || got.fill !== want.fill) begin
               note_bad("mismatch", want, got);
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   initial begin : stimulus
      fifo_result_t      predicted;
      logic              mode;
      logic [CNT_W-1:0]  count;
      logic [DATA_W-1:0] din;
      logic              filling;
      int unsigned       room;
      int unsigned       pick;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = MODE_PUSH;
      req_bit_count = '0;
      req_data_in   = '0;
      req_reverse   = 1'b0;
      csr_valid     = 1'b0;
      csr_wdata     = '0;
      foreach (ring_mem[i]) ring_mem[i] = 8'h00;
      set_capacity(STORE_BYTES);
      tx_idle_pct = 6;
      rx_idle_pct = 56;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_CAP) begin
            wait_drained();
            write_capacity(PLAN[i].cap_value);
         end else begin
            send_word(PLAN[i].mode, PLAN[i].count, PLAN[i].data, PLAN[i].rev, predicted);
            pending_words.push_back(PLAN[i].typed ? PLAN[i].want : predicted);
            sender_gap();
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         tx_idle_pct = (ph < 3) ? 6 : (ph < 6) ? 56 : 0;
         rx_idle_pct = (ph < 3) ? 56 : (ph < 6) ? 6 : 0;
         wait_drained();
         write_capacity(CAP_PLAN[ph]);
         filling = 1'b1;
         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            if (filling) begin
               mode = ($urandom_range(99) < 80) ? MODE_PUSH : MODE_POP;
            end else begin
               mode = ($urandom_range(99) < 80) ? MODE_POP : MODE_PUSH;
            end
            room = (mode == MODE_PUSH) ? cap_bytes * 8 - ring_fill : ring_fill;
            pick = $urandom_range(99);
            if (pick < 70 && room != 0) begin
               count = CNT_W'($urandom_range(1, (room < MAX_BITS) ? room : MAX_BITS));
            end else if (pick < 75) begin
               count = '0;
            end else if (pick < 85) begin
               count = CNT_W'($urandom_range(MAX_BITS + 1, 127));
            end else begin
               count = CNT_W'($urandom_range(1, MAX_BITS));
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
               din = ALL_ONES;
            end else if (pick < 15) begin
               din = '0;
            end else begin
               din = {$urandom, $urandom};
            end
            send_word(mode, count, din, 1'($urandom_range(1)), predicted);
            pending_words.push_back(predicted);
            sender_gap();
            if (predicted.status == ST_NO_SPACE || ring_fill + MAX_BITS > cap_bytes * 8) begin
               filling = 1'b0;
            end else if (predicted.status == ST_UNDERFLOW || ring_fill == 0) begin
               filling = 1'b1;
            end else if ($urandom_range(63) == 0) begin
               filling = ~filling;
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_words == 0 && pending_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
